[hdl/lcd_pkg.sv]
// Shared types and constants for the largest-component search block.
// No dependencies; used by lcd_search and largest_component_dfs.
`default_nettype none

package lcd_pkg;

    localparam int MAX_NODES_DEF = 64;  // default node capacity
    localparam int SIZE_W        = 7;   // node counts, 0..64
    localparam int ROW_W         = 64;  // adjacency row on the stream
    localparam int IDX_IN_W      = 6;   // row index on the stream
    localparam int NODE_COUNT_RST = 64;

    // stream kind carried in tuser
    localparam logic FUNC_ROW = 1'b0;
    localparam logic FUNC_RUN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_POP,
        ST_FETCH,
        ST_EXPAND,
        ST_PUSH,
        ST_DONE
    } lcd_state_t;

    // status from the search engine to the top level
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [SIZE_W-1:0] size;
    } lcd_stat_t;

endpackage

`default_nettype wire

[hdl/lcd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module lcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/lcd_search.sv]
// Search engine: adjacency and stack memories, visited marks and the
// depth-first walk sequencer. Depends on lcd_pkg and lcd_ram.
`default_nettype none

module lcd_search #(
    parameter int MAX_NODES = lcd_pkg::MAX_NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [lcd_pkg::IDX_IN_W-1:0] load_idx,
    input  wire logic [lcd_pkg::ROW_W-1:0]    load_row,
    input  wire logic                        start,
    input  wire logic [lcd_pkg::SIZE_W-1:0]   n_eff,
    input  wire logic                        ack,
    output lcd_pkg::lcd_stat_t               stat
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int DEP_W = IDX_W + 1;
    localparam int SW    = lcd_pkg::SIZE_W;

    lcd_pkg::lcd_state_t state_reg, state_next;

    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [MAX_NODES-1:0] active_reg, active_next;
    logic [MAX_NODES-1:0] pend_reg, pend_next;
    logic [DEP_W-1:0]     depth_reg, depth_next;
    logic [SW-1:0]        root_reg, root_next;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [SW-1:0]        best_reg, best_next;

    // memory ports
    logic                 adj_we;
    logic [IDX_W-1:0]     adj_raddr;
    logic [MAX_NODES-1:0] adj_rdata;
    logic                 stk_we;
    logic [IDX_W-1:0]     stk_waddr;
    logic [IDX_W-1:0]     stk_wdata;
    logic [IDX_W-1:0]     stk_rdata;

    logic                 row_in_range;
    logic [IDX_W-1:0]     root_lo;
    logic                 root_end;
    logic                 root_seen;
    logic [DEP_W-1:0]     depth_dec;
    logic [MAX_NODES-1:0] low_bit;
    logic [IDX_W-1:0]     low_idx;
    logic [MAX_NODES-1:0] nb;
    logic [MAX_NODES-1:0] active_calc;

    assign row_in_range = SW'(load_idx) < SW'(MAX_NODES);
    assign root_lo      = root_reg[IDX_W-1:0];
    assign root_end     = root_reg >= n_eff;
    assign root_seen    = visited_reg[root_lo];
    assign depth_dec    = depth_reg - DEP_W'(1);
    assign low_bit      = pend_reg & (~pend_reg + MAX_NODES'(1));
    assign nb           = adj_rdata & active_reg & ~visited_reg;

    always_comb
    begin
        low_idx = '0;
        for (int j = 0; j < MAX_NODES; j++)
        begin
            if (low_bit[j])
            begin
                low_idx = low_idx | IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_NODES; j++)
        begin
            active_calc[j] = SW'(j) < n_eff;
        end
    end

    lcd_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (load_idx[IDX_W-1:0]),
        .wdata (load_row[MAX_NODES-1:0]),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    lcd_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_NODES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (depth_dec[IDX_W-1:0]),
        .rdata (stk_rdata)
    );

    assign adj_raddr = stk_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lcd_pkg::ST_ROOT;
                end
            end
            lcd_pkg::ST_ROOT:
            begin
                priority if (root_end)
                begin
                    state_next = lcd_pkg::ST_DONE;
                end
                else if (!root_seen)
                begin
                    state_next = lcd_pkg::ST_POP;
                end
                else
                begin
                    state_next = lcd_pkg::ST_ROOT;
                end
            end
            lcd_pkg::ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    state_next = lcd_pkg::ST_ROOT;
                end
                else
                begin
                    state_next = lcd_pkg::ST_FETCH;
                end
            end
            lcd_pkg::ST_FETCH:  state_next = lcd_pkg::ST_EXPAND;
            lcd_pkg::ST_EXPAND: state_next = lcd_pkg::ST_PUSH;
            lcd_pkg::ST_PUSH:
            begin
                if (pend_reg == '0)
                begin
                    state_next = lcd_pkg::ST_POP;
                end
            end
            lcd_pkg::ST_DONE:
            begin
                if (ack)
                begin
                    state_next = lcd_pkg::ST_IDLE;
                end
            end
            default: state_next = lcd_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        visited_next = visited_reg;
        active_next  = active_reg;
        pend_next    = pend_reg;
        depth_next   = depth_reg;
        root_next    = root_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        adj_we       = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = depth_reg[IDX_W-1:0];
        stk_wdata    = low_idx;
        unique case (state_reg)
            lcd_pkg::ST_IDLE:
            begin
                adj_we = load && row_in_range;
                if (start)
                begin
                    visited_next = '0;
                    active_next  = active_calc;
                    best_next    = '0;
                    root_next    = '0;
                    depth_next   = '0;
                end
            end
            lcd_pkg::ST_ROOT:
            begin
                if (!root_end)
                begin
                    if (root_seen)
                    begin
                        root_next = root_reg + SW'(1);
                    end
                    else
                    begin
                        visited_next[root_lo] = 1'b1;
                        cur_next   = '0;
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = root_lo;
                        depth_next = DEP_W'(1);
                    end
                end
            end
            lcd_pkg::ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    if (cur_reg > best_reg)
                    begin
                        best_next = cur_reg;
                    end
                    root_next = root_reg + SW'(1);
                end
                else
                begin
                    depth_next = depth_dec;
                end
            end
            lcd_pkg::ST_FETCH:
            begin
                cur_next = cur_reg + SW'(1);
            end
            lcd_pkg::ST_EXPAND:
            begin
                // mark on push so each node enters the stack once
                visited_next = visited_reg | nb;
                pend_next    = nb;
            end
            lcd_pkg::ST_PUSH:
            begin
                if (pend_reg != '0)
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DEP_W'(1);
                    pend_next  = pend_reg & ~low_bit;
                end
            end
            lcd_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lcd_pkg::ST_IDLE;
            visited_reg <= '0;
            depth_reg   <= '0;
            root_reg    <= '0;
            cur_reg     <= '0;
            best_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            depth_reg   <= depth_next;
            root_reg    <= root_next;
            cur_reg     <= cur_next;
            best_reg    <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg <= active_next;
        pend_reg   <= pend_next;
    end

    assign stat.idle = state_reg == lcd_pkg::ST_IDLE;
    assign stat.done = state_reg == lcd_pkg::ST_DONE;
    assign stat.size = best_reg;

endmodule

`default_nettype wire

[hdl/largest_component_dfs.sv]
// Top level of the largest-component search: stream ports, node count
// register and result register. Depends on lcd_pkg and lcd_search.
`default_nettype none

// Largest connected component by depth-first search. An input transfer with
// tuser = 0 writes one adjacency row (row_index, row_bits) into the row
// memory and gives no result, and row writes may come back to back. A
// transfer with tuser = 1 starts a run: the visited marks and best size are
// cleared, every unvisited node below the node count is taken as a root in
// index order, and a walk with an explicit stack counts the nodes reached
// from it; one result transfer carries the largest count. The result is
// handed over when the output register is free or draining. A run's steps:
// each node index gets a root check; each node a pop, a stack read, an
// adjacency row read and a step to close its pushes; each node reached from
// a root a push; each tree a closing pop; and the run a last root check and
// a hand-over. The pop, read, read chain follows from the registered reads
// of the stack and adjacency memories. No input is taken during a run or
// while its result waits for the output register; a result sitting in the
// output register does not block new row writes. The node count is clamped
// to MAX_NODES where it is used, and a count of zero makes a run return 0.
// Edges to nodes at or above the node count and rows at or above MAX_NODES
// are ignored. Reading a row that was never written gives an undefined
// count.
module largest_component_dfs #(
    parameter int MAX_NODES = lcd_pkg::MAX_NODES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration: node_count
    input  wire logic                      cfg_we,
    input  wire logic [lcd_pkg::SIZE_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [71:0]               s_tdata,  // row_index[5:0], row_bits[69:6], zero
    input  wire logic [0:0]                s_tuser,  // func[0]
    // result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata   // largest_size[6:0], zero
);

    localparam int SW = lcd_pkg::SIZE_W;

    logic [SW-1:0]        node_count_reg;
    logic [SW-1:0]        n_eff;
    logic                 s_xfer;
    logic                 row_load;
    logic                 run_start;
    logic                 take;
    logic                 m_valid_reg, m_valid_next;
    logic [SW-1:0]        m_size_reg, m_size_next;
    lcd_pkg::lcd_stat_t   stat;

    // node count register, clamped to capacity where it is used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= SW'(lcd_pkg::NODE_COUNT_RST);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    assign n_eff = (node_count_reg > SW'(MAX_NODES)) ? SW'(MAX_NODES) : node_count_reg;

    // input accepted only while the engine is idle
    assign s_tready  = stat.idle;
    assign s_xfer    = s_tvalid && s_tready;
    assign row_load  = s_xfer && (s_tuser[0] == lcd_pkg::FUNC_ROW);
    assign run_start = s_xfer && (s_tuser[0] == lcd_pkg::FUNC_RUN);

    // result moves into the output register once it is free or draining
    assign take = stat.done && (!m_valid_reg || m_tready);

    lcd_search #(
        .MAX_NODES (MAX_NODES)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (row_load),
        .load_idx (s_tdata[5:0]),
        .load_row (s_tdata[69:6]),
        .start    (run_start),
        .n_eff    (n_eff),
        .ack      (take),
        .stat     (stat)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_size_next  = m_size_reg;
        priority if (take)
        begin
            m_valid_next = 1'b1;
            m_size_next  = stat.size;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_size_reg <= m_size_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_size_reg};

    // a run closes the input until its result is handed over
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        run_start |=> !s_tready)
        else $error("input still open after a run was accepted");

    // a row write leaves the engine idle
    a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        row_load |=> s_tready)
        else $error("row write left the engine busy");

    // a component never exceeds the node capacity
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (stat.size <= SW'(MAX_NODES)))
        else $error("component size above node capacity");

    // a result handed over returns the engine to idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (s_tready && m_tvalid))
        else $error("result hand-over did not complete");

endmodule

`default_nettype wire
